>>> design/gqi_pkg.sv
// Package: shared types and constants for the quaternion integrator.
package gqi_pkg;

	localparam int QUAT_W   = 32;
	localparam int RATE_W   = 32;
	localparam int QFRAC    = 29;
	localparam int RFRAC    = 23;
	localparam int SQ_W     = 64;
	localparam int ROOT_W   = 32;
	localparam int NUM_W    = 61;
	localparam int MAG_W    = 31;
	localparam logic [SQ_W-1:0] NORM_SQ_MIN = 64'd288230;

	typedef struct packed {
		logic signed [QUAT_W-1:0] quat_w;
		logic signed [QUAT_W-1:0] quat_x;
		logic signed [QUAT_W-1:0] quat_y;
		logic signed [QUAT_W-1:0] quat_z;
		logic signed [RATE_W-1:0] bias_x;
		logic signed [RATE_W-1:0] bias_y;
		logic signed [RATE_W-1:0] rate_x;
		logic signed [RATE_W-1:0] rate_y;
		logic signed [RATE_W-1:0] rate_z;
		logic [31:0]              step_time;
	} gqi_req_t;

	typedef struct packed {
		logic signed [QUAT_W-1:0] new_w;
		logic signed [QUAT_W-1:0] new_x;
		logic signed [QUAT_W-1:0] new_y;
		logic signed [QUAT_W-1:0] new_z;
		logic signed [RATE_W-1:0] held_bias_x;
		logic signed [RATE_W-1:0] held_bias_y;
		logic                     status;
	} gqi_res_t;

	// Item travelling through the root cells
	typedef struct packed {
		logic                   vld;
		logic                   err;
		logic [3:0]             sgn;
		logic [3:0][MAG_W-1:0]  mag;
		logic [SQ_W-1:0]        rem;
		logic [ROOT_W-1:0]      root;
		logic [RATE_W-1:0]      bx;
		logic [RATE_W-1:0]      by;
	} gqi_sq_t;

	typedef struct packed {
		logic                    vld;
		logic                    err;
		logic [3:0]              sgn;
		logic [3:0][NUM_W+1:0]   rem;
		logic [3:0][NUM_W-1:0]   quo;
		logic [ROOT_W:0]         den;
		logic [RATE_W-1:0]       bx;
		logic [RATE_W-1:0]       by;
	} gqi_dv_t;

endpackage

>>> design/gqi_front.sv
// Front end: bias removal, half-angle, quaternion product, norm test and scaling.
module gqi_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld,
	input  gqi_pkg::gqi_req_t req,
	output gqi_pkg::gqi_sq_t  res
);
	import gqi_pkg::*;

	localparam int PW = 42;

	logic                      vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                      dz_s1, dz_s2, dz_s3, dz_s4, dz_s5;
	logic signed [QUAT_W-1:0]  q_s1 [4];
	logic signed [QUAT_W-1:0]  q_s2 [4];
	logic signed [QUAT_W-1:0]  q_s3 [4];
	logic signed [RATE_W:0]    w_s1 [3];
	logic [31:0]               req_dt_s1;
	logic signed [RATE_W+32:0] wd_s2 [3];
	logic signed [RATE_W-1:0]  a_s3 [3];
	logic signed [63:0]        pr_s4 [12];
	logic signed [QUAT_W-1:0]  q_s4 [4];
	logic signed [PW-1:0]      p_s5 [4];
	logic [RATE_W-1:0]         bx_s1, bx_s2, bx_s3, bx_s4, bx_s5, bx_s6, bx_s7;
	logic [RATE_W-1:0]         by_s1, by_s2, by_s3, by_s4, by_s5, by_s6, by_s7;
	logic                      vld_s6, vld_s7, err_s6, err_s7;
	logic [PW-1:0]             mag_s6 [4];
	logic [3:0]                sgn_s6, sgn_s7;
	logic [PW-1:0]             m_s6;
	logic [MAG_W-1:0]          nm_s7 [4];
	logic                      vld_s8;
	gqi_sq_t                   out_s8;

	function automatic logic signed [RATE_W:0] sat_sub(logic signed [RATE_W-1:0] a,
			logic signed [RATE_W-1:0] b);
		logic signed [RATE_W:0] d;
		logic signed [RATE_W:0] mx;
		logic signed [RATE_W:0] mn;
		d  = {a[RATE_W-1], a} - {b[RATE_W-1], b};
		mx = {2'b00, {(RATE_W-1){1'b1}}};
		mn = ~mx;
		if (d > mx) d = mx;
		else if (d < mn) d = mn;
		return d;
	endfunction

	function automatic logic signed [PW-1:0] rnd(logic signed [65:0] v);
		return PW'((v + 66'sd4194304) >>> RFRAC);
	endfunction

	function automatic logic [SQ_W-1:0] sum_sq(logic [PW-1:0] m [4]);
		logic [SQ_W-1:0] s;
		s = '0;
		for (int i = 0; i < 4; i++) s = s + SQ_W'(m[i][29:0]) * SQ_W'(m[i][29:0]);
		return s;
	endfunction

	// Shift so the largest magnitude lands in [2^29, 2^30)
	function automatic logic [MAG_W-1:0] norm_one(logic [PW-1:0] v, logic [PW-1:0] m);
		logic [PW+30:0] t;
		t = {31'd0, v};
		for (int k = PW - 1; k >= 30; k--) begin
			if (m[k]) return MAG_W'(t >> (k - 29));
		end
		for (int k = 29; k >= 0; k--) begin
			if (m[k]) return MAG_W'(t << (29 - k));
		end
		return '0;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= vld; vld_s2 <= vld_s1; vld_s3 <= vld_s2; vld_s4 <= vld_s3;
			vld_s5 <= vld_s4; vld_s6 <= vld_s5; vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		q_s1[0] <= req.quat_w; q_s1[1] <= req.quat_x;
		q_s1[2] <= req.quat_y; q_s1[3] <= req.quat_z;
		w_s1[0] <= sat_sub(req.rate_x, req.bias_x);
		w_s1[1] <= sat_sub(req.rate_y, req.bias_y);
		w_s1[2] <= {req.rate_z[RATE_W-1], req.rate_z};
		dz_s1 <= (req.step_time == 32'd0);
		bx_s1 <= req.bias_x; by_s1 <= req.bias_y;
		for (int i = 0; i < 3; i++) begin
			wd_s2[i] <= w_s1[i] * $signed({1'b0, req_dt_s1});
		end
		q_s2 <= q_s1; dz_s2 <= dz_s1; bx_s2 <= bx_s1; by_s2 <= by_s1;
		for (int i = 0; i < 3; i++) begin
			a_s3[i] <= RATE_W'((wd_s2[i] + (RATE_W+33)'(64'sd1 <<< 32)) >>> 33);
		end
		q_s3 <= q_s2; dz_s3 <= dz_s2; bx_s3 <= bx_s2; by_s3 <= by_s2;
		pr_s4[0]  <= q_s3[1] * a_s3[0]; pr_s4[1]  <= q_s3[2] * a_s3[1];
		pr_s4[2]  <= q_s3[3] * a_s3[2]; pr_s4[3]  <= q_s3[0] * a_s3[0];
		pr_s4[4]  <= q_s3[2] * a_s3[2]; pr_s4[5]  <= q_s3[3] * a_s3[1];
		pr_s4[6]  <= q_s3[0] * a_s3[1]; pr_s4[7]  <= q_s3[1] * a_s3[2];
		pr_s4[8]  <= q_s3[3] * a_s3[0]; pr_s4[9]  <= q_s3[0] * a_s3[2];
		pr_s4[10] <= q_s3[1] * a_s3[1]; pr_s4[11] <= q_s3[2] * a_s3[0];
		q_s4 <= q_s3; dz_s4 <= dz_s3; bx_s4 <= bx_s3; by_s4 <= by_s3;
		p_s5[0] <= PW'(q_s4[0]) + rnd(-(pr_s4[0] + pr_s4[1] + pr_s4[2]));
		p_s5[1] <= PW'(q_s4[1]) + rnd(pr_s4[3] + pr_s4[4] - pr_s4[5]);
		p_s5[2] <= PW'(q_s4[2]) + rnd(pr_s4[6] - pr_s4[7] + pr_s4[8]);
		p_s5[3] <= PW'(q_s4[3]) + rnd(pr_s4[9] + pr_s4[10] - pr_s4[11]);
		dz_s5 <= dz_s4; bx_s5 <= bx_s4; by_s5 <= by_s4;
		for (int i = 0; i < 4; i++) begin
			mag_s6[i] <= p_s5[i][PW-1] ? PW'(-p_s5[i]) : PW'(p_s5[i]);
			sgn_s6[i] <= p_s5[i][PW-1];
		end
		err_s6 <= dz_s5; bx_s6 <= bx_s5; by_s6 <= by_s5;
		err_s7 <= err_s6 || (m_s6 < (PW'(1) << 30) && sum_sq(mag_s6) <= NORM_SQ_MIN);
		for (int i = 0; i < 4; i++) begin
			nm_s7[i] <= norm_one(mag_s6[i], m_s6);
		end
		sgn_s7 <= sgn_s6; bx_s7 <= bx_s6; by_s7 <= by_s6;
	end

	always_ff @(posedge clk) begin
		req_dt_s1 <= req.step_time;
	end

	always_comb begin
		m_s6 = mag_s6[0];
		for (int i = 1; i < 4; i++) if (mag_s6[i] > m_s6) m_s6 = mag_s6[i];
	end

	always_ff @(posedge clk) begin
		out_s8.vld  <= vld_s7;
		out_s8.rem  <= '0;
		out_s8.root <= '0;
		for (int i = 0; i < 4; i++) out_s8.mag[i] <= nm_s7[i];
		out_s8.sgn <= sgn_s7;
		out_s8.err <= err_s7;
		out_s8.bx  <= bx_s7;
		out_s8.by  <= by_s7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else vld_s8 <= vld_s7;
	end

	always_comb begin
		res     = out_s8;
		res.vld = vld_s8;
	end

endmodule

>>> design/gqi_root_cell.sv
// Root cell: one bit of the rounded square root of the sum of squares.
module gqi_root_cell #(
	parameter int BIT = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gqi_pkg::gqi_sq_t din,
	output gqi_pkg::gqi_sq_t dout
);
	import gqi_pkg::*;

	logic [SQ_W-1:0] s;
	logic [SQ_W-1:0] x;
	logic [SQ_W-1:0] trial;
	logic [ROOT_W-1:0] r;
	gqi_sq_t nx;
	gqi_sq_t data_q;
	logic vld_q;

	always_comb begin
		nx = din;
		s = '0;
		for (int i = 0; i < 4; i++) s = s + SQ_W'(din.mag[i]) * SQ_W'(din.mag[i]);
		x = (BIT == ROOT_W - 1) ? s : din.rem;
		r = (BIT == ROOT_W - 1) ? '0 : din.root;
		trial = (SQ_W'(r) << (BIT + 1)) + (SQ_W'(1) << (2 * BIT));
		if (x >= trial) begin
			nx.rem  = x - trial;
			nx.root = r | (ROOT_W'(1) << BIT);
		end else begin
			nx.rem  = x;
			nx.root = r;
		end
		if (BIT == 0 && nx.rem > SQ_W'(nx.root)) nx.root = nx.root + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else vld_q <= din.vld;
	end

	always_ff @(posedge clk) begin
		data_q <= nx;
	end

	always_comb begin
		dout     = data_q;
		dout.vld = vld_q;
	end

endmodule

>>> design/gqi_div_cell.sv
// Divider cell: one restoring quotient bit for all four components.
module gqi_div_cell #(
	parameter int BIT = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gqi_pkg::gqi_dv_t din,
	output gqi_pkg::gqi_dv_t dout
);
	import gqi_pkg::*;

	gqi_dv_t nx;
	logic [NUM_W+1:0] sh;
	gqi_dv_t data_q;
	logic vld_q;

	always_comb begin
		nx = din;
		for (int i = 0; i < 4; i++) begin
			sh = (NUM_W+2)'(din.den) << BIT;
			if (din.rem[i] >= sh) begin
				nx.rem[i] = din.rem[i] - sh;
				nx.quo[i] = din.quo[i] | (NUM_W'(1) << BIT);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else vld_q <= din.vld;
	end

	always_ff @(posedge clk) begin
		data_q <= nx;
	end

	always_comb begin
		dout     = data_q;
		dout.vld = vld_q;
	end

endmodule

>>> design/gyro_quaternion_integrator.sv
// Top level: pipelined quaternion integrator with root and divider cell chains.
//
// channel  | ports                      | width | handshake
// request  | start, busy, req           | 320   | taken when start && !busy
// result   | done, res                  | 193   | one-cycle strobe on done
//
// One request per cycle; busy stays low. Each request passes through the
// front pipeline, one root cell per root bit, one divider cell per
// quotient bit and the output register. Reset clears only the valid
// chain. The receiver cannot stall, so no result is ever held back.
module gyro_quaternion_integrator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  gqi_pkg::gqi_req_t req,
	output logic              done,
	output gqi_pkg::gqi_res_t res
);
	import gqi_pkg::*;

	localparam int QB = QFRAC + 2;

	gqi_sq_t sq [ROOT_W+1];
	gqi_dv_t dv [QB+1];
	gqi_res_t res_q;
	logic done_q;
	logic [NUM_W-1:0] o;
	logic signed [QUAT_W-1:0] v [4];

	assign busy = 1'b0;

	gqi_front u_front (
		.clk(clk), .arst_n(arst_n), .vld(start && !busy), .req(req), .res(sq[0])
	);

	for (genvar g = 0; g < ROOT_W; g++) begin : g_root
		gqi_root_cell #(.BIT(ROOT_W - 1 - g)) u_cell (
			.clk(clk), .arst_n(arst_n), .din(sq[g]), .dout(sq[g+1])
		);
	end

	always_comb begin
		dv[0].vld = sq[ROOT_W].vld;
		dv[0].err = sq[ROOT_W].err;
		dv[0].sgn = sq[ROOT_W].sgn;
		dv[0].den = {1'b0, sq[ROOT_W].root};
		dv[0].bx  = sq[ROOT_W].bx;
		dv[0].by  = sq[ROOT_W].by;
		dv[0].quo = '0;
		for (int i = 0; i < 4; i++) begin
			dv[0].rem[i] = ((NUM_W+2)'(sq[ROOT_W].mag[i]) << QFRAC)
				+ (NUM_W+2)'(sq[ROOT_W].root >> 1);
		end
	end

	for (genvar g = 0; g < QB; g++) begin : g_div
		gqi_div_cell #(.BIT(QB - 1 - g)) u_cell (
			.clk(clk), .arst_n(arst_n), .din(dv[g]), .dout(dv[g+1])
		);
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			o = dv[QB].quo[i];
			if (dv[QB].err) v[i] = '0;
			else if (o > NUM_W'(1 << 30)) v[i] = dv[QB].sgn[i] ? -(32'sd1 <<< 30) : 32'sd1 <<< 30;
			else v[i] = dv[QB].sgn[i] ? -QUAT_W'(o) : QUAT_W'(o);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= dv[QB].vld;
	end

	always_ff @(posedge clk) begin
		res_q.new_w <= v[0];
		res_q.new_x <= v[1];
		res_q.new_y <= v[2];
		res_q.new_z <= v[3];
		res_q.held_bias_x <= dv[QB].bx;
		res_q.held_bias_y <= dv[QB].by;
		res_q.status <= dv[QB].err;
	end

	assign done = done_q;
	assign res  = res_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.status |-> res.new_w == '0 && res.new_z == '0)
		else $error("error result carries non-zero quaternion");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.new_w <= (32'sd1 <<< 30) && res.new_w >= -(32'sd1 <<< 30))
		else $error("quaternion output out of range");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(dv[QB].vld))
		else $error("result strobe without item");

endmodule
